// File: rtl/sbm_pkg.sv
// Shared widths, register indexes and reset values for the row sorter.
package sbm_pkg;

  // Element word width (signed Q8.8)
  localparam int DATA_W = 16;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 4'd3;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 4'd2;

  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

// File: rtl/sbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/sort_rows_by_max_top.sv
// Top level of the row sorter: load a matrix, order rows by maximum, stream it out.
//
// The block takes a num_rows by num_cols matrix of signed Q8.8 words in row-major
// order, one word per cycle, and stores it in a 64-entry element RAM while it
// tracks each row's maximum. After the last word it ranks the rows, one row per
// cycle, largest maximum first and on equal maxima the higher original row first.
// It then streams the reordered matrix in row-major order through the registered
// RAM read and the single output register, with tlast on the final word; no new
// read is issued while one is pending. No input is taken from the last loaded
// word until the final output word is taken. A register write drops any partial
// matrix. Register values of 0 act as 1 and values above the maximum act as the
// maximum.
module sort_rows_by_max_top #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata_i fields, low bit up: elem_value[15:0]
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [sbm_pkg::DATA_W-1:0]    s_axis_tdata_i,
  // m_axis_tdata_o fields, low bit up: out_value[15:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sbm_pkg::DATA_W-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_we_i,
  input  logic [sbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sbm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import sbm_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic [CFG_W-1:0] rows_eff, cols_eff;

  logic [RW-1:0] ld_row_q;
  logic [CW-1:0] ld_col_q;
  elem_t         cur_peak_q;
  elem_t         peak_q [MAX_ROWS];
  logic [RW-1:0] order_q [MAX_ROWS];
  logic [RW-1:0] sort_idx_q;
  logic [RW-1:0] rank;

  logic [RW-1:0] em_row_q;
  logic [CW-1:0] em_col_q;
  logic          issued_all_q, rd_pend_q, rd_last_q;
  logic          out_valid_q, out_last_q;
  logic [DATA_W-1:0] out_data_q;

  logic          in_acc, out_acc, rd_issue;
  logic          ld_col_end, ld_row_end, em_col_end, em_row_end;
  elem_t         in_val, new_peak, pk_i;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Clamp the dimensions into the supported range
  always_comb begin
    rows_eff = num_rows_q;
    if (num_rows_q == '0) rows_eff = CFG_W'(1);
    else if (num_rows_q > CFG_W'(MAX_ROWS)) rows_eff = CFG_W'(MAX_ROWS);
    cols_eff = num_cols_q;
    if (num_cols_q == '0) cols_eff = CFG_W'(1);
    else if (num_cols_q > CFG_W'(MAX_COLS)) cols_eff = CFG_W'(MAX_COLS);
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = out_valid_q && m_axis_tready_i;
  assign in_val  = s_axis_tdata_i;

  assign ld_col_end = (CFG_W'(ld_col_q) == cols_eff - CFG_W'(1));
  assign ld_row_end = (CFG_W'(ld_row_q) == rows_eff - CFG_W'(1));
  assign em_col_end = (CFG_W'(em_col_q) == cols_eff - CFG_W'(1));
  assign em_row_end = (CFG_W'(em_row_q) == rows_eff - CFG_W'(1));

  // Running maximum of the row being loaded
  assign new_peak = (ld_col_q == '0 || in_val > cur_peak_q) ? in_val : cur_peak_q;

  // Rank of the row under test: count rows that go ahead of it
  assign pk_i = peak_q[sort_idx_q];
  always_comb begin
    rank = '0;
    for (int j = 0; j < MAX_ROWS; j++) begin
      if (CFG_W'(j) < rows_eff && RW'(j) != sort_idx_q) begin
        if (peak_q[j] > pk_i || (peak_q[j] == pk_i && RW'(j) > sort_idx_q)) begin
          rank = rank + RW'(1);
        end
      end
    end
  end

  // Issue a RAM read when the output register will be free to take it
  assign rd_issue = (state_q == ST_EMIT) && !issued_all_q && !rd_pend_q &&
                    (!out_valid_q || m_axis_tready_i);

  assign ram_waddr = AW'(ld_row_q) * AW'(MAX_COLS) + AW'(ld_col_q);
  assign ram_raddr = AW'(order_q[em_row_q]) * AW'(MAX_COLS) + AW'(em_col_q);

  sbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rd_issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_acc && ld_col_end && ld_row_end) state_d = ST_SORT;
      ST_SORT: if (CFG_W'(sort_idx_q) == rows_eff - CFG_W'(1)) state_d = ST_EMIT;
      ST_EMIT: if (out_acc && out_last_q) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      num_rows_q   <= NUM_ROWS_RST;
      num_cols_q   <= NUM_COLS_RST;
      ld_row_q     <= '0;
      ld_col_q     <= '0;
      sort_idx_q   <= '0;
      em_row_q     <= '0;
      em_col_q     <= '0;
      issued_all_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_issue;

      // load position; a register write drops the partial matrix
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_ROWS) num_rows_q <= cfg_wdata_i;
        if (cfg_idx_i == CFG_NUM_COLS) num_cols_q <= cfg_wdata_i;
        ld_row_q <= '0;
        ld_col_q <= '0;
      end else if (in_acc) begin
        if (ld_col_end) begin
          ld_col_q <= '0;
          ld_row_q <= ld_row_end ? '0 : ld_row_q + RW'(1);
        end else begin
          ld_col_q <= ld_col_q + CW'(1);
        end
      end

      // ranking walk
      if (state_q == ST_SORT) begin
        sort_idx_q <= (state_d == ST_EMIT) ? '0 : sort_idx_q + RW'(1);
      end

      // emit read position
      if (rd_issue) begin
        if (em_col_end) begin
          em_col_q <= '0;
          if (em_row_end) begin
            em_row_q     <= '0;
            issued_all_q <= 1'b1;
          end else begin
            em_row_q <= em_row_q + RW'(1);
          end
        end else begin
          em_col_q <= em_col_q + CW'(1);
        end
      end else if (out_acc && out_last_q) begin
        issued_all_q <= 1'b0;
      end

      // output register
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_peak_q <= new_peak;
      if (ld_col_end) peak_q[ld_row_q] <= new_peak;
    end
    if (state_q == ST_SORT) begin
      order_q[rank] <= sort_idx_q;
    end
    if (rd_issue) begin
      rd_last_q <= em_col_end && em_row_end;
    end
    if (rd_pend_q) begin
      out_data_q <= ram_rdata;
      out_last_q <= rd_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: rtl/sbm_checker.sv
// Port-level checks for the row sorter, bound to its top level.
module sbm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [sbm_pkg::DATA_W-1:0] m_axis_tdata_o,
  input logic                       m_axis_tlast_o
);

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while an output word is offered");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // Taking the final word reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("input not ready after final output word");

  // Mid-burst, the input stays closed
  a_burst_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> !s_axis_tready_o)
    else $error("input opened before the burst ended");

endmodule

bind sort_rows_by_max_top sbm_checker u_sbm_checker (.*);

// File: bench/tb.sv
// Self-checking bench for sort_rows_by_max_top: directed and random matrices, scored per word.
module tb;
  import sbm_pkg::*;

  localparam int MAX_ROWS      = 8;
  localparam int MAX_COLS      = 8;
  localparam int SETTLE_CYCLES = 2 * MAX_ROWS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    elem_t value;
    logic  last;
  } out_word_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [DATA_W-1:0]    s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = CFG_NUM_ROWS;
  logic [CFG_W-1:0]     cfg_wdata_i     = '0;

  // Predicted matrix state, mirrors the block's registers and stores
  elem_t            elem_mem [MAX_ROWS*MAX_COLS];
  elem_t            peak_mem [MAX_ROWS];
  int               load_cnt = 0;
  logic [CFG_W-1:0] rows_reg = NUM_ROWS_RST;
  logic [CFG_W-1:0] cols_reg = NUM_COLS_RST;
  out_word_t        sorted_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int errors      = 0;
  int cycles      = 0;
  int n_in        = 0;
  int n_out       = 0;
  int n_mat       = 0;

  sort_rows_by_max_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // 0 acts as 1, anything above the bound acts as the bound
  function automatic int dim_in_use(input logic [CFG_W-1:0] v, input int bound);
    if (v == 0) return 1;
    if (int'(v) > bound) return bound;
    return int'(v);
  endfunction

  // Row a goes out before row b: bigger peak first, ties to the higher row
  function automatic bit row_ahead(input int a, input int b);
    if (peak_mem[a] != peak_mem[b]) return peak_mem[a] > peak_mem[b];
    return a > b;
  endfunction

  // Load one word; on the closing word rank the rows and queue the burst
  task automatic load_and_rank(input elem_t v);
    int        rows, cols, total, r, c, pos;
    int        order [MAX_ROWS];
    out_word_t w;
    rows  = dim_in_use(rows_reg, MAX_ROWS);
    cols  = dim_in_use(cols_reg, MAX_COLS);
    total = rows * cols;
    if (load_cnt >= total) load_cnt = 0;
    r = load_cnt / cols;
    c = load_cnt % cols;
    elem_mem[r*MAX_COLS + c] = v;
    if (c == 0 || v > peak_mem[r]) peak_mem[r] = v;
    load_cnt++;
    if (load_cnt < total) return;
    load_cnt = 0;
    n_mat++;
    // position of a row = number of rows that go ahead of it
    for (int a = 0; a < rows; a++) begin
      pos = 0;
      for (int b = 0; b < rows; b++) begin
        if (b != a && row_ahead(b, a)) pos++;
      end
      order[pos] = a;
    end
    for (int p = 0; p < rows; p++) begin
      for (int k = 0; k < cols; k++) begin
        w.value = elem_mem[order[p]*MAX_COLS + k];
        w.last  = (p == rows - 1) && (k == cols - 1);
        sorted_q.insert(sorted_q.size(), w);
      end
    end
  endtask

  // Monitor: register writes, accepted words in, checked words out
  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_ROWS: rows_reg = cfg_wdata_i;
          CFG_NUM_COLS: cols_reg = cfg_wdata_i;
          default: ;
        endcase
        load_cnt = 0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        n_in++;
        load_and_rank(elem_t'(s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_out++;
        if (sorted_q.size() == 0) begin
          $error("unexpected word: out_value %h out_last %b", m_axis_tdata_o, m_axis_tlast_o);
          errors++;
        end else begin
          w = sorted_q.pop_front();
          if (m_axis_tdata_o !== w.value) begin
            $error("out_value: expected %h, got %h", w.value, m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tlast_o !== w.last) begin
            $error("out_last: expected %b, got %b", w.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random ready, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sort_rows_by_max_top test failed");
      $finish;
    end
  end

  // Offer one word, with random gaps ahead of it; returns on acceptance
  task automatic send_word(input elem_t v);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stop offering, wait for every queued word, then let the block go idle
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Extremes and small clusters so that equal row peaks show up often
  function automatic elem_t pick_value();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(3)) - 16'd2;
      default: return elem_t'($urandom());
    endcase
  endfunction

  // Mostly small sizes, sometimes out of range, now and then the largest
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(9))
      7, 8:    return 4'($urandom_range(15));
      9:       return 4'($urandom_range(8, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_matrix(input int n_words);
    repeat (n_words) send_word(pick_value());
  endtask

  // Reset size 3x2 with extreme words and a tie on the row peaks
  task automatic test_reset_size();
    elem_t vals [6] = '{16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000};
    tx_idle_pct = 20;
    rx_idle_pct = 66;
    foreach (vals[i]) send_word(vals[i]);
  endtask

  // Zero rows acts as one, fifteen columns as eight; nine rows as eight
  task automatic test_clamped_size();
    elem_t row_vals [8] = '{16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
                            16'h0100, 16'h7FFE, 16'h8001, 16'h0000};
    elem_t col_vals [8] = '{16'h0005, 16'h0005, 16'h7FFF, 16'h8000,
                            16'h8000, 16'h7FFF, 16'h0000, 16'h0005};
    write_reg(CFG_NUM_ROWS, 4'd0);
    write_reg(CFG_NUM_COLS, 4'd15);
    foreach (row_vals[i]) send_word(row_vals[i]);
    write_reg(CFG_NUM_ROWS, 4'd9);
    write_reg(CFG_NUM_COLS, 4'd1);
    foreach (col_vals[i]) send_word(col_vals[i]);
  endtask

  // A register write in the middle of a load drops the partial matrix
  task automatic test_abandoned_load();
    write_reg(CFG_NUM_ROWS, 4'd2);
    write_reg(CFG_NUM_COLS, 4'd2);
    send_word(16'h1234);
    send_word(16'h8000);
    write_reg(CFG_NUM_COLS, 4'd1);
    send_word(16'hFF00);
    send_word(16'h00FF);
  endtask

  // Full matrices of random size and content, now and then a partial one
  task automatic test_random_matrices(input int tx_pct, input int rx_pct, input int n_items);
    int               sent, total, part;
    logic [CFG_W-1:0] rv, cv;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      rv = pick_dim();
      cv = pick_dim();
      write_reg(CFG_NUM_ROWS, rv);
      write_reg(CFG_NUM_COLS, cv);
      total = dim_in_use(rv, MAX_ROWS) * dim_in_use(cv, MAX_COLS);
      repeat ($urandom_range(1, 3)) begin
        send_matrix(total);
        sent += total;
      end
      if (total > 1 && $urandom_range(4) == 0) begin
        part = $urandom_range(1, total - 1);
        send_matrix(part);
        sent += part;
      end
    end
  endtask

  // Receiver holds off through a full 8x8 burst while words keep coming
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_NUM_ROWS, 4'd8);
    write_reg(CFG_NUM_COLS, 4'd8);
    hold_req = 1'b1;
    send_matrix(64);
    send_matrix(4);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_clamped_size();
    test_abandoned_load();
    test_random_matrices(20, 66, 50);
    test_random_matrices(66, 20, 50);
    test_random_matrices(0, 0, 50);
    test_output_stall();
    settle();
    errors += sorted_q.size();
    $display("%0d matrices ranked from %0d words in, %0d words out", n_mat, n_in, n_out);
    $display("sizes 1x1 to 8x8, clamped sizes, peak ties, dropped loads, long output stall");
    if (errors == 0) begin
      $display("sort_rows_by_max_top test passed");
    end else begin
      $display("sort_rows_by_max_top test failed");
    end
    $finish;
  end

endmodule
